@@ src/rfrt_pkg.sv @@
// ---------------------------------------------------------------------------
// rfrt_pkg
// Shared codes, widths and types for the rs485 frame receive timeout block
// ---------------------------------------------------------------------------
package rfrt_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIMER_WIDTH_DEF = 16;

    localparam int OP_W      = 3;
    localparam int LEN_W     = 16;
    localparam int TO_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W = 16;
    localparam int IN_USER_W = 8;
    localparam int OUT_DATA_W = 24;

    // event codes
    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_BYTE        = 3'd1;
    localparam logic [OP_W-1:0] OP_TX_EMPTY    = 3'd2;
    localparam logic [OP_W-1:0] OP_START_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_START_WRITE = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_WAIT  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    // link status carried between the step logic and its registers
    typedef struct packed {
        mode_t             mode;
        logic              got_bytes;
        logic              sent_done;
        logic [LEN_W-1:0]  last_length;
    } link_t;

    // result item, link_state in the lowest bits
    typedef struct packed {
        logic              transmitted_flag;
        logic              received_flag;
        logic [LEN_W-1:0]  received_length;
        logic              frame_done;
        logic              drive_enable;
        logic              accepted;
        logic              busy_res;
        logic [1:0]        link_state;
    } result_t;

endpackage

@@ src/rs485_frame_receive_timeout.sv @@
// ---------------------------------------------------------------------------
// rs485_frame_receive_timeout
// Half-duplex link controller with receive idle timeouts
// ---------------------------------------------------------------------------
// the input item is registered first, then its step result is registered as the output
// throughput: one item per cycle, sustained while the result side keeps up
// the link state update is a single compare and counter step per item
// synchronous active-low reset: link idle, counters and flags zero, registers zero
// ---------------------------------------------------------------------------
module rs485_frame_receive_timeout
    import rfrt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // max_length[15:0]
    input  logic [IN_USER_W-1:0]  s_tuser,   // op[2:0], zeros above

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // link_state[1:0], busy_res, accepted,
                                             // drive_enable, frame_done,
                                             // received_length[15:0], received_flag,
                                             // transmitted_flag
);

    logic                   enable_reg;
    logic [TO_W-1:0]        pre_timeout_reg;
    logic [TO_W-1:0]        post_timeout_reg;

    logic                   in_valid_reg;
    logic [OP_W-1:0]        in_op_reg;
    logic [LEN_W-1:0]       in_len_reg;

    link_t                  link_reg;
    link_t                  link_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg;
    logic [TIMER_WIDTH-1:0] elapsed_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] limit_reg;
    logic [COUNT_WIDTH-1:0] limit_next;

    result_t                result_next;
    result_t                result_reg;
    logic                   m_tvalid_reg;

    logic                   advance;
    logic                   step_fire;

    assign cfg_ready = 1'b1;
    assign advance   = !m_tvalid_reg || m_tready;
    assign step_fire = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = result_reg;

    rfrt_step #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .enable       (enable_reg),
        .pre_timeout  (pre_timeout_reg),
        .post_timeout (post_timeout_reg),
        .op           (in_op_reg),
        .max_length   (in_len_reg),
        .link_in      (link_reg),
        .elapsed_in   (elapsed_reg),
        .count_in     (count_reg),
        .limit_in     (limit_reg),
        .link_next    (link_next),
        .elapsed_next (elapsed_next),
        .count_next   (count_next),
        .limit_next   (limit_next),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg       <= 1'b0;
            pre_timeout_reg  <= '0;
            post_timeout_reg <= '0;
            in_valid_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            link_reg         <= '{mode: MODE_IDLE, got_bytes: 1'b0, sent_done: 1'b0,
                                  last_length: '0};
            elapsed_reg      <= '0;
            count_reg        <= '0;
            limit_reg        <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENABLE:       enable_reg       <= cfg_data[0];
                    CFG_PRE_TIMEOUT:  pre_timeout_reg  <= cfg_data;
                    CFG_POST_TIMEOUT: post_timeout_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_tvalid_reg <= in_valid_reg;
            end
            if (step_fire) begin
                link_reg    <= link_next;
                elapsed_reg <= elapsed_next;
                count_reg   <= count_next;
                limit_reg   <= limit_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg  <= s_tuser[OP_W-1:0];
            in_len_reg <= s_tdata[LEN_W-1:0];
        end
        if (step_fire) begin
            result_reg <= result_next;
        end
    end

    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> m_tvalid_reg)
        else $error("processed item did not produce a result");

    a_count_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= limit_reg)
        else $error("byte count beyond receive limit");

    a_done_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && result_reg.frame_done) |-> (result_reg.link_state == MODE_IDLE))
        else $error("frame done while link still busy");

    a_accept_is_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && result_reg.accepted)
            |-> (result_reg.busy_res && (result_reg.link_state != MODE_IDLE)))
        else $error("accepted start left link idle");

endmodule

@@ src/rfrt_step.sv @@
// ---------------------------------------------------------------------------
// rfrt_step
// Next-state and result logic for one link event
// ---------------------------------------------------------------------------
module rfrt_step
    import rfrt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                   enable,
    input  logic [TO_W-1:0]        pre_timeout,
    input  logic [TO_W-1:0]        post_timeout,
    input  logic [OP_W-1:0]        op,
    input  logic [LEN_W-1:0]       max_length,
    input  link_t                  link_in,
    input  logic [TIMER_WIDTH-1:0] elapsed_in,
    input  logic [COUNT_WIDTH-1:0] count_in,
    input  logic [COUNT_WIDTH-1:0] limit_in,
    output link_t                  link_next,
    output logic [TIMER_WIDTH-1:0] elapsed_next,
    output logic [COUNT_WIDTH-1:0] count_next,
    output logic [COUNT_WIDTH-1:0] limit_next,
    output result_t                result
);

    localparam int TCMP_W = (TIMER_WIDTH > TO_W) ? TIMER_WIDTH : TO_W;
    localparam int LCMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    mode_t                  mode_cur;
    logic                   rx_active;
    logic [TO_W-1:0]        timeout_sel;
    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic                   time_up;
    logic [COUNT_WIDTH-1:0] req_limit;
    logic                   acc;
    logic                   done;

    assign mode_cur    = enable ? link_in.mode : MODE_IDLE;
    assign rx_active   = (mode_cur == MODE_WAIT) || (mode_cur == MODE_READ);
    assign timeout_sel = (mode_cur == MODE_WAIT) ? pre_timeout : post_timeout;
    assign elapsed_inc = (elapsed_in == TMAX) ? elapsed_in : elapsed_in + 1'b1;
    // timeout above the timer range counts as the timer maximum
    assign time_up     = (TCMP_W'(elapsed_inc) >= TCMP_W'(timeout_sel))
                         || (elapsed_inc == TMAX);
    assign req_limit   = (LCMP_W'(max_length) > LCMP_W'(CMAX)) ? CMAX
                                                                : COUNT_WIDTH'(max_length);

    always_comb begin
        link_next      = link_in;
        link_next.mode = mode_cur;
        elapsed_next   = elapsed_in;
        count_next     = count_in;
        limit_next     = limit_in;
        acc            = 1'b0;
        done           = 1'b0;
        case (op)
            OP_TICK: begin
                if (rx_active) begin
                    elapsed_next = elapsed_inc;
                    if (time_up) begin
                        link_next.last_length = LEN_W'(count_in);
                        link_next.got_bytes   = (count_in != '0);
                        link_next.mode        = MODE_IDLE;
                        done                  = 1'b1;
                    end
                end
            end
            OP_BYTE: begin
                if (rx_active && (count_in < limit_in)) begin
                    count_next     = count_in + 1'b1;
                    elapsed_next   = '0;
                    link_next.mode = MODE_READ;
                end
            end
            OP_TX_EMPTY: begin
                if (mode_cur == MODE_WRITE) begin
                    link_next.sent_done = 1'b1;
                    link_next.mode      = MODE_IDLE;
                    done                = 1'b1;
                end
            end
            OP_START_READ: begin
                if (enable && (mode_cur == MODE_IDLE)) begin
                    limit_next            = req_limit;
                    count_next            = '0;
                    elapsed_next          = '0;
                    link_next.last_length = '0;
                    link_next.got_bytes   = 1'b0;
                    link_next.mode        = MODE_WAIT;
                    acc                   = 1'b1;
                end
            end
            OP_START_WRITE: begin
                if (enable && (mode_cur == MODE_IDLE)) begin
                    link_next.sent_done = 1'b0;
                    link_next.mode      = MODE_WRITE;
                    acc                 = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.link_state       = link_next.mode;
        result.busy_res         = (link_next.mode != MODE_IDLE);
        result.accepted         = acc;
        result.drive_enable     = (link_next.mode == MODE_WRITE);
        result.frame_done       = done;
        result.received_length  = link_next.last_length;
        result.received_flag    = link_next.got_bytes;
        result.transmitted_flag = link_next.sent_done;
    end

endmodule

@@ tb/tb_rs485_frame_receive_timeout.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rs485_frame_receive_timeout
// Self-checking testbench for the half-duplex link controller. Directed
// tests cover a disabled link, write frames, read frames with first-byte
// and idle timeouts, the byte limit and dropping a transfer by disable.
// Random read and write frames mixed with stray events then run under
// several source idle and sink stall patterns, including a long sink
// hold-off. A behavioral link model predicts every result item and a
// monitor compares each output transfer field by field.
// ---------------------------------------------------------------------------
module tb_rs485_frame_receive_timeout;
    import rfrt_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // max_length[15:0]
    logic [IN_USER_W-1:0]  s_tuser = '0;   // op[2:0], zeros above
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // link_state[1:0], busy_res, accepted,
                                           // drive_enable, frame_done,
                                           // received_length[15:0], received_flag,
                                           // transmitted_flag

    // link model state and registers
    logic                  lk_enable = 1'b0;
    logic [TO_W-1:0]       lk_pre = '0;
    logic [TO_W-1:0]       lk_post = '0;
    mode_t                 lk_mode = MODE_IDLE;
    logic [TO_W-1:0]       lk_elapsed = '0;
    logic [LEN_W-1:0]      lk_bytes = '0;
    logic [LEN_W-1:0]      lk_limit = '0;
    logic [LEN_W-1:0]      lk_last_len = '0;
    logic                  lk_got = 1'b0;
    logic                  lk_sent = 1'b0;

    result_t status_q[$];
    int      err_cnt = 0;
    int      items_sent = 0;
    int      cycle_cnt = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_len = 0;
    int      hold_seq = 0;
    int      hold_seen = 0;
    int      hold_left = 0;

    rs485_frame_receive_timeout i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // sink side: random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // one event through the link, returns the status after it
    function automatic result_t link_step(input logic [OP_W-1:0] op,
                                          input logic [LEN_W-1:0] req_len);
        result_t         r;
        logic            taken;
        logic            ended;
        logic [TO_W-1:0] limit;
        taken = 1'b0;
        ended = 1'b0;
        if (!lk_enable)
            lk_mode = MODE_IDLE;
        case (op)
            OP_TICK: begin
                if (lk_mode == MODE_WAIT || lk_mode == MODE_READ) begin
                    limit = (lk_mode == MODE_WAIT) ? lk_pre : lk_post;
                    if (lk_elapsed != '1)
                        lk_elapsed++;
                    if (lk_elapsed >= limit) begin
                        lk_last_len = lk_bytes;
                        lk_got      = (lk_bytes != 0);
                        lk_mode     = MODE_IDLE;
                        ended       = 1'b1;
                    end
                end
            end
            OP_BYTE: begin
                if ((lk_mode == MODE_WAIT || lk_mode == MODE_READ) && lk_bytes < lk_limit) begin
                    lk_bytes++;
                    lk_elapsed = '0;
                    lk_mode    = MODE_READ;
                end
            end
            OP_TX_EMPTY: begin
                if (lk_mode == MODE_WRITE) begin
                    lk_sent = 1'b1;
                    lk_mode = MODE_IDLE;
                    ended   = 1'b1;
                end
            end
            OP_START_READ: begin
                if (lk_enable && lk_mode == MODE_IDLE) begin
                    lk_limit    = req_len;
                    lk_bytes    = '0;
                    lk_elapsed  = '0;
                    lk_last_len = '0;
                    lk_got      = 1'b0;
                    lk_mode     = MODE_WAIT;
                    taken       = 1'b1;
                end
            end
            OP_START_WRITE: begin
                if (lk_enable && lk_mode == MODE_IDLE) begin
                    lk_sent = 1'b0;
                    lk_mode = MODE_WRITE;
                    taken   = 1'b1;
                end
            end
            default: ;
        endcase
        r.link_state       = lk_mode;
        r.busy_res         = (lk_mode != MODE_IDLE);
        r.accepted         = taken;
        r.drive_enable     = (lk_mode == MODE_WRITE);
        r.frame_done       = ended;
        r.received_length  = lk_last_len;
        r.received_flag    = lk_got;
        r.transmitted_flag = lk_sent;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
        if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
        end
    endtask

    // output monitor, handshake sampled half a cycle ahead of the edge
    always @(negedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (status_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%0t: unexpected result %0h", $realtime, m_tdata);
            end else begin
                want = status_q.pop_front();
                check_field("link_state", LEN_W'(want.link_state),
                            LEN_W'(got.link_state));
                check_field("busy_res", LEN_W'(want.busy_res), LEN_W'(got.busy_res));
                check_field("accepted", LEN_W'(want.accepted), LEN_W'(got.accepted));
                check_field("drive_enable", LEN_W'(want.drive_enable),
                            LEN_W'(got.drive_enable));
                check_field("frame_done", LEN_W'(want.frame_done),
                            LEN_W'(got.frame_done));
                check_field("received_length", want.received_length, got.received_length);
                check_field("received_flag", LEN_W'(want.received_flag),
                            LEN_W'(got.received_flag));
                check_field("transmitted_flag", LEN_W'(want.transmitted_flag),
                            LEN_W'(got.transmitted_flag));
            end
        end
    end

    // called at a rising edge, returns at the edge of the transfer
    task automatic send_event(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] len);
        bit hs;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= len;
        s_tuser  <= {{(IN_USER_W-OP_W){1'b0}}, op};
        do begin
            @(negedge aclk);
            hs = s_tvalid && s_tready;
            if (hs)
                status_q.push_back(link_step(op, len));
            @(posedge aclk);
        end while (!hs);
        items_sent++;
    endtask

    // source pauses until every expected result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (status_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        bit hs;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
            hs = cfg_valid && cfg_ready;
            if (hs) begin
                case (idx)
                    CFG_ENABLE:       lk_enable = val[0];
                    CFG_PRE_TIMEOUT:  lk_pre = val;
                    CFG_POST_TIMEOUT: lk_post = val;
                    default: ;
                endcase
            end
            @(posedge aclk);
        end while (!hs);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [LEN_W-1:0] random_len();
        if ($urandom_range(0, 99) < 70)
            return LEN_W'($urandom_range(0, 8));
        return LEN_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [OP_W-1:0] random_body_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return OP_TICK;
        if (r < 90)
            return OP_BYTE;
        return OP_W'($urandom_range(0, 7));
    endfunction

    task automatic test_disabled_link();
        send_event(OP_START_READ, 16'd5);
        send_event(OP_START_WRITE, 16'hffff);
        send_event(OP_BYTE, 16'd0);
        send_event(OP_TX_EMPTY, 16'd0);
        send_event(OP_TICK, 16'd0);
        send_event(3'd7, 16'hffff);
        drain_results();
    endtask

    task automatic test_write_frame();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_PRE_TIMEOUT, 16'd0);
        write_reg(CFG_POST_TIMEOUT, 16'd0);
        send_event(OP_START_WRITE, 16'd0);
        send_event(OP_START_READ, 16'd0);
        send_event(OP_BYTE, 16'd0);
        send_event(OP_TICK, 16'd0);
        send_event(OP_TX_EMPTY, 16'd0);
        send_event(OP_TX_EMPTY, 16'd0);
        drain_results();
    endtask

    task automatic test_read_frames();
        // zero limit: byte ignored, first tick ends the wait
        send_event(OP_START_READ, 16'd0);
        send_event(OP_BYTE, 16'd0);
        send_event(OP_TICK, 16'd0);
        drain_results();
        write_reg(CFG_PRE_TIMEOUT, 16'd2);
        write_reg(CFG_POST_TIMEOUT, 16'd1);
        send_event(OP_START_READ, 16'd2);
        send_event(OP_TICK, 16'd0);
        send_event(OP_BYTE, 16'd0);
        send_event(OP_BYTE, 16'd0);
        send_event(OP_BYTE, 16'd0);
        send_event(OP_TICK, 16'd0);
        // no byte: pre-timeout ends the read
        send_event(OP_START_READ, 16'hffff);
        send_event(OP_TICK, 16'd0);
        send_event(OP_TICK, 16'd0);
        drain_results();
    endtask

    task automatic test_disable_drop();
        write_reg(CFG_PRE_TIMEOUT, 16'hffff);
        write_reg(CFG_POST_TIMEOUT, 16'hffff);
        send_event(OP_START_READ, 16'd3);
        send_event(OP_BYTE, 16'd0);
        drain_results();
        write_reg(CFG_ENABLE, 16'd0);
        send_event(OP_TICK, 16'd0);
        send_event(OP_START_READ, 16'd4);
        drain_results();
        write_reg(CFG_ENABLE, 16'd1);
    endtask

    task automatic test_traffic(input int idle_pct, input int stall_pct,
                                input logic [TO_W-1:0] pre, input logic [TO_W-1:0] post,
                                input int n_items);
        int target;
        int r;
        int k;
        drain_results();
        write_reg(CFG_PRE_TIMEOUT, pre);
        write_reg(CFG_POST_TIMEOUT, post);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + n_items;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_event(OP_START_READ, random_len());
                k = $urandom_range(0, 10);
                repeat (k) send_event(random_body_op(), random_len());
                k = $urandom_range(0, 12);
                repeat (k) send_event(OP_TICK, random_len());
            end else if (r < 85) begin
                send_event(OP_START_WRITE, random_len());
                k = $urandom_range(0, 4);
                repeat (k) send_event(random_body_op(), random_len());
                if ($urandom_range(0, 9) != 0)
                    send_event(OP_TX_EMPTY, random_len());
            end else begin
                send_event(OP_W'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 65535)));
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len <= 300;
        hold_seq <= hold_seq + 1;
        send_event(OP_START_READ, 16'd6);
        for (k = 0; k < 40; k++)
            send_event(random_body_op(), random_len());
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled_link();
        test_write_frame();
        test_read_frames();
        test_disable_drop();
        test_traffic(0, 0, 16'd0, 16'd0, 300);
        test_traffic(53, 0, TO_W'($urandom_range(1, 6)), TO_W'($urandom_range(1, 6)), 300);
        test_backpressure();
        test_traffic(0, 53, TO_W'($urandom_range(0, 10)), TO_W'($urandom_range(0, 10)), 300);
        test_traffic(29, 29, TO_W'($urandom_range(2, 4)), TO_W'($urandom_range(2, 4)), 300);
        repeat (8) @(posedge aclk);
        if (err_cnt == 0 && status_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/rfrt_pkg.sv
src/rfrt_step.sv
src/rs485_frame_receive_timeout.sv
tb/tb_rs485_frame_receive_timeout.sv
